/* src/gmcs_pkg.sv */
// ----------------------------------------------------------------------------
// gmcs_pkg
// Shared sizes, codes and controller/datapath handshake types for the grammar
// mode context stack.
// ----------------------------------------------------------------------------
package gmcs_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int MODE_SLOTS  = 16;

    localparam int SLOT_W     = (MODE_SLOTS > 1) ? $clog2(MODE_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(MODE_SLOTS + 1);
    localparam int STK_W      = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W  = $clog2(STACK_DEPTH + 1);

    localparam int CMD_W      = 3;
    localparam int TOKEN_W    = 16;
    localparam int MODE_W     = 8;
    localparam int OFFSET_W   = 32;
    localparam int CODE_W     = 17;
    localparam int LEVEL_W    = 16;
    localparam int NEST_W     = 5;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 72;

    localparam logic [CODE_W-1:0]  EXIT_BY_DEPTH = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 16'h7fff;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN     = 16'h8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER = 3'd0,
        CMD_SWITCH   = 3'd1,
        CMD_EXIT     = 3'd2,
        CMD_PUSH     = 3'd3,
        CMD_POP      = 3'd4,
        CMD_OPEN     = 3'd5,
        CMD_CLOSE    = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        CHG_NONE = 2'd0,
        CHG_PUSH = 2'd1,
        CHG_POP  = 2'd2
    } t_change;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic post;
    } t_ctrl;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

/* src/gmcs_ctrl.sv */
// ----------------------------------------------------------------------------
// gmcs_ctrl
// Controller: accepts an item, steps the slot scan, commits, then loads the
// result register.
// ----------------------------------------------------------------------------
module gmcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gmcs_pkg::t_status i_status,
    output gmcs_pkg::t_ctrl   o_ctrl
);
    import gmcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_POST
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   accept;

    assign accept     = i_in_valid && r_ready;
    assign o_in_ready = r_ready;

    always_comb begin
        o_ctrl      = '0;
        o_ctrl.load = accept;
        o_ctrl.scan = (r_state == ST_SCAN);
        o_ctrl.exec = (r_state == ST_EXEC);
        o_ctrl.post = (r_state == ST_POST) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SCAN;
                        r_ready <= 1'b0;
                    end else begin
                        r_ready <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (i_status.scan_done) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_POST;
                end
                ST_POST: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

/* src/gmcs_dpath.sv */
// ----------------------------------------------------------------------------
// gmcs_dpath
// Datapath: item registers, mode table, context stack, bracket counter, slot
// scan and result register.
// ----------------------------------------------------------------------------
module gmcs_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gmcs_pkg::t_ctrl                  i_ctrl,
    output gmcs_pkg::t_status                o_status,
    input  logic [gmcs_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [gmcs_pkg::CMD_W-1:0]       i_in_user,
    input  logic                             i_cfg_valid,
    input  logic [gmcs_pkg::MODE_W-1:0]      i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [gmcs_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import gmcs_pkg::*;

    // item
    t_cmd                r_cmd;
    logic [TOKEN_W-1:0]  r_tok;
    logic [MODE_W-1:0]   r_mode;
    logic [OFFSET_W-1:0] r_offs;
    logic [CODE_W-1:0]   r_trig;
    logic [CODE_W-1:0]   r_exit;

    // mode table
    logic [MODE_W-1:0]     r_tbl_mode [MODE_SLOTS];
    logic [CODE_W-1:0]     r_tbl_trig [MODE_SLOTS];
    logic [CODE_W-1:0]     r_tbl_exit [MODE_SLOTS];
    logic [SLOT_CNT_W-1:0] r_tbl_cnt;

    // context stack
    logic [MODE_W-1:0]    r_stk_mode  [STACK_DEPTH];
    logic [LEVEL_W-1:0]   r_stk_level [STACK_DEPTH];
    logic [OFFSET_W-1:0]  r_stk_off   [STACK_DEPTH];
    logic [STK_CNT_W-1:0] r_stk_cnt;

    logic [LEVEL_W-1:0] r_bc;
    logic [MODE_W-1:0]  r_root;

    // scan and result
    logic [SLOT_CNT_W-1:0] r_scan;
    logic                  r_found;
    logic                  r_ok;
    t_change               r_change;
    logic [MODE_W-1:0]     r_from;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [STK_CNT_W-1:0]   stk_cnt_m1;
    logic [STK_W-1:0]       top_idx;
    logic                   at_root;
    logic [MODE_W-1:0]      top_mode;
    logic [OFFSET_W-1:0]    top_off;
    logic [STK_CNT_W+4:0]   nest_ext;
    logic [SLOT_W-1:0]      slot;
    logic                   scan_end;
    logic [MODE_W-1:0]      key_mode;
    logic                   key_hit;
    logic                   need_scan;
    logic                   hit;
    logic                   scan_done;

    logic                   can_push;
    logic                   can_pop;
    logic [LEVEL_W-1:0]     bc_inc;
    logic [LEVEL_W-1:0]     bc_dec;
    logic [LEVEL_W-1:0]     n_bc;
    logic                   n_ok;
    t_change                n_change;
    logic [MODE_W-1:0]      push_mode;
    logic                   do_reg;
    logic                   do_push;
    logic                   do_pop;

    assign stk_cnt_m1 = r_stk_cnt - 1'b1;
    assign top_idx    = stk_cnt_m1[STK_W-1:0];
    assign at_root    = (r_stk_cnt < STK_CNT_W'(2));
    assign top_mode   = at_root ? r_root : r_stk_mode[top_idx];
    assign top_off    = at_root ? '0 : r_stk_off[top_idx];
    assign nest_ext   = {5'b0, stk_cnt_m1};

    assign slot     = r_scan[SLOT_W-1:0];
    assign scan_end = (r_scan == r_tbl_cnt);
    assign key_mode = (r_cmd == CMD_EXIT || r_cmd == CMD_CLOSE) ? top_mode : r_mode;

    always_comb begin
        key_hit   = 1'b0;
        need_scan = 1'b1;
        case (r_cmd)
            CMD_SWITCH: begin
                key_hit = !r_tbl_trig[slot][CODE_W-1] && (r_tbl_trig[slot][TOKEN_W-1:0] == r_tok);
            end
            CMD_REGISTER, CMD_EXIT, CMD_PUSH, CMD_CLOSE: begin
                key_hit = (r_tbl_mode[slot] == key_mode);
            end
            default: begin
                need_scan = 1'b0;
            end
        endcase
    end

    assign hit       = !scan_end && key_hit;
    assign scan_done = !need_scan || scan_end || key_hit;

    assign o_status.scan_done = scan_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign can_push = (r_stk_cnt < STK_CNT_W'(STACK_DEPTH));
    assign can_pop  = !at_root;
    assign bc_inc   = (r_bc == LEVEL_MAX) ? r_bc : r_bc + 1'b1;
    assign bc_dec   = (r_bc == LEVEL_MIN) ? r_bc : r_bc - 1'b1;

    always_comb begin
        n_ok      = 1'b0;
        n_change  = CHG_NONE;
        n_bc      = r_bc;
        push_mode = r_mode;
        do_reg    = 1'b0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        case (r_cmd)
            CMD_REGISTER: begin
                do_reg = (r_tbl_cnt < SLOT_CNT_W'(MODE_SLOTS)) && !r_found;
            end
            CMD_SWITCH: begin
                push_mode = r_tbl_mode[slot];
                do_push   = r_found && can_push;
            end
            CMD_EXIT: begin
                do_pop = can_pop && r_found && !r_tbl_exit[slot][CODE_W-1]
                         && (r_tbl_exit[slot][TOKEN_W-1:0] == r_tok);
            end
            CMD_PUSH: begin
                do_push = r_found && can_push;
            end
            CMD_POP: begin
                do_pop = can_pop;
            end
            CMD_OPEN: begin
                n_bc = bc_inc;
                n_ok = 1'b1;
            end
            CMD_CLOSE: begin
                n_bc   = bc_dec;
                do_pop = can_pop && r_found && (r_tbl_exit[slot] == EXIT_BY_DEPTH)
                         && ($signed(bc_dec) < $signed(r_stk_level[top_idx]));
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        if (do_reg || do_push || do_pop) begin
            n_ok = 1'b1;
        end
        if (do_push) begin
            n_change = CHG_PUSH;
        end else if (do_pop) begin
            n_change = CHG_POP;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= t_cmd'(i_in_user);
            r_tok  <= i_in_data[15:0];
            r_mode <= i_in_data[23:16];
            r_offs <= i_in_data[55:24];
            r_trig <= i_in_data[72:56];
            r_exit <= i_in_data[89:73];
        end
        if (i_ctrl.exec) begin
            r_ok     <= n_ok;
            r_change <= n_change;
            r_from   <= top_mode;
            if (do_reg) begin
                r_tbl_mode[r_tbl_cnt[SLOT_W-1:0]] <= r_mode;
                r_tbl_trig[r_tbl_cnt[SLOT_W-1:0]] <= r_trig;
                r_tbl_exit[r_tbl_cnt[SLOT_W-1:0]] <= r_exit;
            end
            if (do_push) begin
                r_stk_mode[r_stk_cnt[STK_W-1:0]]  <= push_mode;
                r_stk_level[r_stk_cnt[STK_W-1:0]] <= r_bc;
                r_stk_off[r_stk_cnt[STK_W-1:0]]   <= r_offs;
            end
        end
        if (i_ctrl.post) begin
            r_out_data <= {top_off, r_bc, nest_ext[NEST_W-1:0], top_mode, r_from,
                           r_change, r_ok};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_cnt   <= '0;
            r_stk_cnt   <= STK_CNT_W'(1);
            r_bc        <= '0;
            r_root      <= '0;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_root <= i_cfg_data;
            end
            if (i_ctrl.load) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end else if (i_ctrl.scan) begin
                if (hit) begin
                    r_found <= 1'b1;
                end
                if (!scan_done) begin
                    r_scan <= r_scan + 1'b1;
                end
            end
            if (i_ctrl.exec) begin
                r_bc <= n_bc;
                if (do_reg) begin
                    r_tbl_cnt <= r_tbl_cnt + 1'b1;
                end
                if (do_push) begin
                    r_stk_cnt <= r_stk_cnt + 1'b1;
                end else if (do_pop) begin
                    r_stk_cnt <= stk_cnt_m1;
                end
            end
            if (i_ctrl.post) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/grammar_mode_context_stack.sv */
// ----------------------------------------------------------------------------
// grammar_mode_context_stack
// Mode table with trigger/exit tokens, context stack and saturating bracket
// counter; one result item per command item.
//
//   channel   dir   signals                      contents
//   s_axis    in    tvalid tready tdata tuser    command item
//   m_axis    out   tvalid tready tdata          result item
//   cfg       in    valid ready data             root_mode register
//
// An item is accepted only while the block is idle, so a new item waits until
// the last one has been scanned, committed and loaded into the result register;
// commands other than POP and OPEN scan the mode table linearly, one slot per cycle.
// Reset empties the mode table, leaves only the root entry on the stack and
// clears the bracket counter and root_mode; s_axis and cfg become ready in the
// cycle after reset is released, and cfg is taken only while s_axis is ready.
// A result waits in the output register while the block is accepting the next
// item; the next result is held back until m_axis takes the previous one.
// ----------------------------------------------------------------------------
module grammar_mode_context_stack (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // token, mode_id, src_offset, trigger_code, exit_code, zero pad
    input  logic [gmcs_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // command
    input  logic [gmcs_pkg::CMD_W-1:0]       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // success, change, from_mode, to_mode, nesting, bracket_level, top_offset
    output logic [gmcs_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gmcs_pkg::MODE_W-1:0]      i_cfg_data
);
    import gmcs_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    assign o_cfg_ready = o_s_axis_tready;

    gmcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    gmcs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

/* tb/gmcs_checker.sv */
// ----------------------------------------------------------------------------
// gmcs_checker
// Watches the command, result and root_mode channels of the grammar mode
// context stack. Keeps its own mode table, context stack and bracket counter,
// predicts the result of every accepted command and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gmcs_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_valid,
    input  logic                               i_s_ready,
    // token, mode_id, src_offset, trigger_code, exit_code, zero pad
    input  logic [gmcs_pkg::IN_DATA_W-1:0]     i_s_data,
    // command
    input  logic [gmcs_pkg::CMD_W-1:0]         i_s_user,
    input  logic                               i_m_valid,
    input  logic                               i_m_ready,
    // success, change, from_mode, to_mode, nesting, bracket_level, top_offset
    input  logic [gmcs_pkg::OUT_DATA_W-1:0]    i_m_data,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [gmcs_pkg::MODE_W-1:0]        i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import gmcs_pkg::*;

    typedef struct packed {
        logic [5:0]                pad;
        logic signed [CODE_W-1:0]  exit_code;
        logic signed [CODE_W-1:0]  trigger_code;
        logic [OFFSET_W-1:0]       src_offset;
        logic [MODE_W-1:0]         mode_id;
        logic [TOKEN_W-1:0]        token;
    } t_cmd_item;

    typedef struct packed {
        logic [OFFSET_W-1:0]       top_offset;
        logic signed [LEVEL_W-1:0] bracket_level;
        logic [NEST_W-1:0]         nesting;
        logic [MODE_W-1:0]         to_mode;
        logic [MODE_W-1:0]         from_mode;
        logic [1:0]                change;
        logic                      success;
    } t_ctx_result;

    logic [MODE_W-1:0]          root_mode_q;
    logic [MODE_W-1:0]          slot_mode    [MODE_SLOTS];
    logic signed [CODE_W-1:0]   slot_trigger [MODE_SLOTS];
    logic signed [CODE_W-1:0]   slot_exit    [MODE_SLOTS];
    logic [SLOT_CNT_W-1:0]      slot_count;
    logic [MODE_W-1:0]          ctx_mode     [STACK_DEPTH];
    logic signed [LEVEL_W-1:0]  ctx_level    [STACK_DEPTH];
    logic [OFFSET_W-1:0]        ctx_offset   [STACK_DEPTH];
    logic [STK_CNT_W-1:0]       ctx_count;
    logic signed [LEVEL_W-1:0]  bracket;

    t_ctx_result awaited_results[$];
    t_ctx_result got_result;
    t_ctx_result want_result;
    int          results_seen;

    function automatic logic [MODE_W-1:0] current_mode();
        return (ctx_count <= 1) ? root_mode_q : ctx_mode[ctx_count-1];
    endfunction

    function automatic int lookup_slot(input logic [MODE_W-1:0] mode);
        for (int i = 0; i < slot_count; i++) begin
            if (slot_mode[i] == mode) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit push_context(input logic [MODE_W-1:0] mode,
                                        input logic [OFFSET_W-1:0] offset);
        if (ctx_count >= STACK_DEPTH || lookup_slot(mode) < 0) begin
            return 1'b0;
        end
        ctx_mode[ctx_count]   = mode;
        ctx_level[ctx_count]  = bracket;
        ctx_offset[ctx_count] = offset;
        ctx_count = ctx_count + 1'b1;
        return 1'b1;
    endfunction

    function automatic bit pop_context();
        if (ctx_count <= 1) begin
            return 1'b0;
        end
        ctx_count = ctx_count - 1'b1;
        return 1'b1;
    endfunction

    function automatic string show_result(input t_ctx_result r);
        return $sformatf("ok=%0d chg=%0d from=%h to=%h nest=%0d lvl=%0d off=%h",
                         r.success, r.change, r.from_mode, r.to_mode, r.nesting,
                         r.bracket_level, r.top_offset);
    endfunction

    function automatic t_ctx_result run_context_command(input logic [CMD_W-1:0] cmd,
                                                        input t_cmd_item it);
        t_ctx_result r;
        int          s;
        bit          hit;
        r = '0;
        r.from_mode = current_mode();
        case (cmd)
            CMD_REGISTER: begin
                if (slot_count < MODE_SLOTS && lookup_slot(it.mode_id) < 0) begin
                    slot_mode[slot_count]    = it.mode_id;
                    slot_trigger[slot_count] = it.trigger_code;
                    slot_exit[slot_count]    = it.exit_code;
                    slot_count = slot_count + 1'b1;
                    r.success = 1'b1;
                end
            end
            CMD_SWITCH: begin
                hit = 1'b0;
                for (int i = 0; i < slot_count && !hit; i++) begin
                    if (!slot_trigger[i][CODE_W-1] &&
                            slot_trigger[i][TOKEN_W-1:0] == it.token) begin
                        hit = 1'b1;
                        if (push_context(slot_mode[i], it.src_offset)) begin
                            r.success = 1'b1;
                            r.change  = CHG_PUSH;
                        end
                    end
                end
            end
            CMD_EXIT: begin
                if (ctx_count > 1) begin
                    s = lookup_slot(current_mode());
                    if (s >= 0 && !slot_exit[s][CODE_W-1] &&
                            slot_exit[s][TOKEN_W-1:0] == it.token && pop_context()) begin
                        r.success = 1'b1;
                        r.change  = CHG_POP;
                    end
                end
            end
            CMD_PUSH: begin
                if (push_context(it.mode_id, it.src_offset)) begin
                    r.success = 1'b1;
                    r.change  = CHG_PUSH;
                end
            end
            CMD_POP: begin
                if (pop_context()) begin
                    r.success = 1'b1;
                    r.change  = CHG_POP;
                end
            end
            CMD_OPEN: begin
                if (bracket != LEVEL_MAX) begin
                    bracket = bracket + 16'sd1;
                end
                r.success = 1'b1;
            end
            CMD_CLOSE: begin
                if (bracket != LEVEL_MIN) begin
                    bracket = bracket - 16'sd1;
                end
                if (ctx_count > 1) begin
                    s = lookup_slot(current_mode());
                    if (s >= 0 && slot_exit[s] == EXIT_BY_DEPTH &&
                            bracket < ctx_level[ctx_count-1] && pop_context()) begin
                        r.success = 1'b1;
                        r.change  = CHG_POP;
                    end
                end
            end
            default: begin
            end
        endcase
        r.to_mode       = current_mode();
        r.nesting       = NEST_W'(ctx_count - 1'b1);
        r.bracket_level = bracket;
        r.top_offset    = (ctx_count <= 1) ? '0 : ctx_offset[ctx_count-1];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_mode_q = '0;
            slot_count  = '0;
            ctx_count   = 1;
            bracket     = '0;
            awaited_results.delete();
        end else begin
            if (i_m_valid && i_m_ready) begin
                got_result   = t_ctx_result'(i_m_data);
                results_seen = results_seen + 1;
                if (awaited_results.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("result %0d arrived with no command waiting: %h",
                                 results_seen, i_m_data);
                    end
                end else begin
                    want_result = awaited_results.pop_front();
                    if (got_result.success !== want_result.success ||
                            got_result.change !== want_result.change ||
                            got_result.from_mode !== want_result.from_mode ||
                            got_result.to_mode !== want_result.to_mode ||
                            got_result.nesting !== want_result.nesting ||
                            got_result.bracket_level !== want_result.bracket_level ||
                            got_result.top_offset !== want_result.top_offset) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("result %0d expected %s", results_seen,
                                     show_result(want_result));
                            $display("result %0d got      %s", results_seen,
                                     show_result(got_result));
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                root_mode_q = i_cfg_data;
            end
            if (i_s_valid && i_s_ready) begin
                awaited_results.push_back(
                    run_context_command(i_s_user, t_cmd_item'(i_s_data)));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the grammar mode context stack with a directed opening sequence,
// random command streams under three idle patterns and a stack fill, with
// root_mode rewritten between phases. Checking is done by gmcs_checker
// beside the block.
// ----------------------------------------------------------------------------
module tb;
    import gmcs_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 3'd7;
    localparam logic [CODE_W-1:0] NO_TRIGGER = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   s_valid;
    logic                   s_ready;
    logic [IN_DATA_W-1:0]   s_data;
    logic [CMD_W-1:0]       s_user;
    logic                   m_valid;
    logic                   m_ready;
    logic [OUT_DATA_W-1:0]  m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [MODE_W-1:0]      cfg_data;
    int                     fail_count;
    int                     pending;
    int                     send_idle;
    int                     recv_idle;

    grammar_mode_context_stack DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    gmcs_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial begin
        #40_000_000;
        $display("** grammar_mode_context_stack: FAILED **");
        $finish;
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TOKEN_W-1:0] tok,
                            input logic [MODE_W-1:0] mode, input logic [OFFSET_W-1:0] offs,
                            input logic [CODE_W-1:0] trig, input logic [CODE_W-1:0] ex);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {6'b0, ex, trig, offs, mode, tok};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
    endtask

    task automatic send_bare(input logic [CMD_W-1:0] cmd);
        send_cmd(cmd, TOKEN_W'($urandom), MODE_W'($urandom), $urandom,
                 CODE_W'($urandom), CODE_W'($urandom));
    endtask

    task automatic write_root(input logic [MODE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, then let the block settle after the last result
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (25) @(negedge clk);
    endtask

    task automatic random_item();
        int                  r;
        logic [CMD_W-1:0]    cmd;
        logic [TOKEN_W-1:0]  tok;
        logic [MODE_W-1:0]   mode;
        logic [CODE_W-1:0]   trig;
        logic [CODE_W-1:0]   ex;
        r = $urandom_range(0, 99);
        if (r < 10)      cmd = CMD_REGISTER;
        else if (r < 35) cmd = CMD_SWITCH;
        else if (r < 50) cmd = CMD_EXIT;
        else if (r < 60) cmd = CMD_PUSH;
        else if (r < 68) cmd = CMD_POP;
        else if (r < 82) cmd = CMD_OPEN;
        else if (r < 98) cmd = CMD_CLOSE;
        else             cmd = CMD_UNUSED;
        tok = ($urandom_range(0, 9) < 7) ? TOKEN_W'($urandom_range(0, 7)) : TOKEN_W'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            mode = $urandom_range(0, 1) ? MODE_W'($urandom_range(0, 7))
                                        : MODE_W'($urandom_range(248, 255));
        end else begin
            mode = MODE_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 60)      trig = CODE_W'($urandom_range(0, 7));
        else if (r < 75) trig = NO_TRIGGER;
        else if (r < 80) trig = {1'b1, TOKEN_W'($urandom)};
        else             trig = CODE_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40)      ex = CODE_W'($urandom_range(0, 7));
        else if (r < 75) ex = EXIT_BY_DEPTH;
        else if (r < 85) ex = {1'b1, TOKEN_W'($urandom)};
        else             ex = CODE_W'($urandom);
        send_cmd(cmd, tok, mode, $urandom, trig, ex);
    endtask

    task automatic random_phase(input int sender_idle, input int receiver_idle,
                                input int count);
        send_idle = sender_idle;
        recv_idle = receiver_idle;
        repeat (count) random_item();
    endtask

    initial begin
        rst_n     = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_user    = CMD_REGISTER;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        send_idle = 0;
        recv_idle = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        write_root(8'hff);

        // root-only stack, empty table
        send_cmd(CMD_POP,      16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_EXIT,     16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_CLOSE,    16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_OPEN,     16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_PUSH,     16'h0000, 8'h00, 32'h1,        17'h00000, 17'h00000);
        send_cmd(CMD_SWITCH,   16'h0000, 8'h00, 32'h2,        17'h00000, 17'h00000);
        // registrations, duplicate refused
        send_cmd(CMD_REGISTER, 16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00001);
        send_cmd(CMD_REGISTER, 16'h0000, 8'hff, 32'h0,        17'h0ffff, EXIT_BY_DEPTH);
        send_cmd(CMD_REGISTER, 16'h0000, 8'h10, 32'h0,        NO_TRIGGER, 17'h10000);
        send_cmd(CMD_REGISTER, 16'h0000, 8'h20, 32'h0,        17'h10000, 17'h0ffff);
        send_cmd(CMD_REGISTER, 16'h0000, 8'hff, 32'h0,        17'h00002, 17'h00002);
        // token switch and token exit
        send_cmd(CMD_SWITCH,   16'h0000, 8'h00, 32'hffffffff, 17'h00000, 17'h00000);
        send_cmd(CMD_EXIT,     16'h1234, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_EXIT,     16'h0001, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_SWITCH,   16'hffff, 8'h00, 32'h00000000, 17'h00000, 17'h00000);
        // exit by bracket depth
        send_cmd(CMD_OPEN,     16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_CLOSE,    16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_CLOSE,    16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        // mode that never exits, then token exit, pop and unused command
        send_cmd(CMD_PUSH,     16'h0000, 8'h10, 32'ha5a5a5a5, 17'h00000, 17'h00000);
        send_cmd(CMD_CLOSE,    16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_EXIT,     16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_PUSH,     16'h0000, 8'h20, 32'h5a5a5a5a, 17'h00000, 17'h00000);
        send_cmd(CMD_EXIT,     16'hffff, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_POP,      16'h0000, 8'h00, 32'h0,        17'h00000, 17'h00000);
        send_cmd(CMD_UNUSED,   16'hffff, 8'hff, 32'hffffffff, 17'h1ffff, 17'h1ffff);
        drain();

        write_root(8'h00);
        random_phase(35, 52, 270);
        drain();

        write_root(MODE_W'($urandom_range(1, 254)));
        random_phase(52, 35, 270);
        drain();

        write_root(8'hff);
        random_phase(0, 0, 270);
        // fill the stack past its depth, then empty it
        repeat (34) send_cmd(CMD_PUSH, TOKEN_W'($urandom), 8'h00, $urandom,
                             CODE_W'($urandom), CODE_W'($urandom));
        repeat (34) send_bare(CMD_POP);
        drain();

        if (fail_count == 0) begin
            $display("** grammar_mode_context_stack: PASSED **");
        end else begin
            $display("** grammar_mode_context_stack: FAILED **");
        end
        $finish;
    end

endmodule
